// ===== src/rpet_pkg.sv =====
// Package for the relative pose extrinsic transform core: types, constants, helpers.
package rpet_pkg;

    localparam logic [63:0] START_RESET = 64'd1559027026016899800;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    // configuration register indexes
    localparam logic [2:0] CFG_START  = 3'd0;
    localparam logic [2:0] CFG_ROT0   = 3'd1;
    localparam logic [2:0] CFG_ROT1   = 3'd2;
    localparam logic [2:0] CFG_ROT2   = 3'd3;
    localparam logic [2:0] CFG_TX     = 3'd4;
    localparam logic [2:0] CFG_TY     = 3'd5;
    localparam logic [2:0] CFG_TZ     = 3'd6;

    // shared MAC unit command
    typedef struct packed {
        logic               clr;   // start new accumulation
        logic               acc;   // accumulate product this cycle
        logic signed [32:0] a;     // multiplicand (33-bit signed)
        logic signed [17:0] b;     // multiplier (18-bit signed)
    } t_mac_cmd;

    // round half up then arithmetic shift right
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                     input logic [3:0] s);
        logic signed [63:0] y;
        y = x + (64'sd1 <<< (s - 4'd1));
        return y >>> s;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
        if (x < -64'sd32768)
            return -16'sd32768;
        else if (x > 64'sd32767)
            return 16'sd32767;
        return x[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x < -64'sd2147483648)
            return 32'h8000_0000;
        else if (x > 64'sd2147483647)
            return 32'h7fff_ffff;
        return x[31:0];
    endfunction

endpackage

// ===== src/rpet_mac.sv =====
// Shared multiply-accumulate unit: one 33x18 signed product per cycle into a 64-bit sum.
module rpet_mac (
    input  logic                 i_clk,
    input  rpet_pkg::t_mac_cmd   i_cmd,
    output logic signed [63:0]   o_acc
);

    logic signed [50:0] w_prod;
    logic signed [63:0] r_acc;

    assign w_prod = i_cmd.a * i_cmd.b;

    // accumulator register
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            if (i_cmd.clr)
                r_acc <= 64'(w_prod);
            else
                r_acc <= r_acc + 64'(w_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== src/relative_pose_extrinsic_transform_core.sv =====
// Top level: relative pose in the sensor frame from world poses and extrinsic calibration.
// One pose request passes from acceptance to a valid result through a stamp check,
// the quaternion-to-matrix terms, the three 3x3 matrix products, the translation
// dot products and the load of the result register, in that order.
// Every product runs one per cycle through a single 33x18 multiplier with a 64-bit
// accumulator, under a small sequencer. s_axis_tready is low while a pose is in work,
// so a new pose is taken only after the previous one is through; a finished pose waits
// in its last step only while the previous result is still unaccepted. A pose stamped
// before start_time_ns is dropped after the stamp check; the first accepted pose becomes
// the reference and gives no result.
// rel_rot rows pack three signed Q1.14 entries, column 0 in the low 16 bits.
module relative_pose_extrinsic_transform_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration write port
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    // input poses
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // stamp_ns[63:0], quat_x[78:64], quat_y[93:79], quat_z[108:94], quat_w[123:109],
    // pos_x[155:124], pos_y[187:156], pos_z[219:188], zero fill [223:220]
    input  logic [223:0]  s_axis_tdata,
    // results
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // frame_index[31:0], out_stamp_ns[95:32], rel_rot_row0[143:96],
    // rel_rot_row1[191:144], rel_rot_row2[239:192], rel_trans_x[271:240],
    // rel_trans_y[303:272], rel_trans_z[335:304]
    output logic [335:0]  m_axis_tdata
);

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_QUAT, S_MAT, S_TRANS, S_OUT} t_state;

    // configuration
    logic [63:0]        r_start;
    logic signed [15:0] r_rc [3][3];
    logic signed [31:0] r_tc [3];

    // state
    logic [31:0]        r_count;
    logic signed [15:0] r_wref [3][3];
    logic signed [31:0] r_tref [3];

    // work registers
    t_state             r_state;
    logic [63:0]        r_stamp;
    logic signed [14:0] r_q [4];
    logic signed [31:0] r_pos [3];
    logic signed [15:0] r_w [3][3];
    logic signed [15:0] r_a [3][3];
    logic signed [15:0] r_b [3][3];
    logic signed [15:0] r_r [3][3];
    logic signed [31:0] r_t [3];
    logic signed [35:0] r_p1;     // rounded A*(tref-t) of the current row
    logic [1:0]         r_pass;   // matrix pass 0:A 1:B 2:R
    logic [3:0]         r_elem;   // output element 0..8
    logic [2:0]         r_k;      // term index (one extra value for the accumulator result)
    logic [335:0]       r_out;
    logic               r_oval;

    rpet_pkg::t_mac_cmd w_cmd;
    logic signed [63:0] w_acc;

    rpet_mac u_mac (.i_clk(i_clk), .i_cmd(w_cmd), .o_acc(w_acc));

    logic [1:0] w_i, w_j, w_kk;
    assign w_kk = (r_k == 3'd3) ? 2'd0 : r_k[1:0];

    // row and column of the current element
    always_comb begin
        unique case (r_elem)
            4'd0:    begin w_i = 2'd0; w_j = 2'd0; end
            4'd1:    begin w_i = 2'd0; w_j = 2'd1; end
            4'd2:    begin w_i = 2'd0; w_j = 2'd2; end
            4'd3:    begin w_i = 2'd1; w_j = 2'd0; end
            4'd4:    begin w_i = 2'd1; w_j = 2'd1; end
            4'd5:    begin w_i = 2'd1; w_j = 2'd2; end
            4'd6:    begin w_i = 2'd2; w_j = 2'd0; end
            4'd7:    begin w_i = 2'd2; w_j = 2'd1; end
            default: begin w_i = 2'd2; w_j = 2'd2; end
        endcase
    end

    // quaternion term operands: per element up to two products with signs
    logic signed [14:0] w_qa, w_qb;
    logic               w_qneg;
    always_comb begin
        logic [1:0] x0, x1, y0, y1;
        logic       n1;
        x0 = 2'd0; y0 = 2'd0; x1 = 2'd0; y1 = 2'd0; n1 = 1'b0;
        // indexes: x=0 y=1 z=2 w=3
        case (r_elem)
            4'd0: begin x0 = 2'd1; y0 = 2'd1; x1 = 2'd2; y1 = 2'd2; end
            4'd1: begin x0 = 2'd0; y0 = 2'd1; x1 = 2'd2; y1 = 2'd3; n1 = 1'b1; end
            4'd2: begin x0 = 2'd0; y0 = 2'd2; x1 = 2'd1; y1 = 2'd3; end
            4'd3: begin x0 = 2'd0; y0 = 2'd1; x1 = 2'd2; y1 = 2'd3; end
            4'd4: begin x0 = 2'd0; y0 = 2'd0; x1 = 2'd2; y1 = 2'd2; end
            4'd5: begin x0 = 2'd1; y0 = 2'd2; x1 = 2'd0; y1 = 2'd3; n1 = 1'b1; end
            4'd6: begin x0 = 2'd0; y0 = 2'd2; x1 = 2'd1; y1 = 2'd3; n1 = 1'b1; end
            4'd7: begin x0 = 2'd1; y0 = 2'd2; x1 = 2'd0; y1 = 2'd3; end
            default: begin x0 = 2'd0; y0 = 2'd0; x1 = 2'd1; y1 = 2'd1; end
        endcase
        if (r_k[0]) begin
            w_qa = r_q[x1]; w_qb = r_q[y1]; w_qneg = n1;
        end else begin
            w_qa = r_q[x0]; w_qb = r_q[y0]; w_qneg = 1'b0;
        end
    end

    // MAC command per state
    always_comb begin
        logic signed [15:0] ma, mb;
        w_cmd.clr = (r_k == 3'd0);
        w_cmd.acc = 1'b0;
        w_cmd.a   = '0;
        w_cmd.b   = '0;
        ma = '0; mb = '0;
        unique case (r_state)
            S_QUAT: begin
                w_cmd.acc = (r_k < 3'd2);
                w_cmd.a   = 33'(w_qa);
                w_cmd.b   = w_qneg ? -18'(w_qb) : 18'(w_qb);
            end
            S_MAT: begin
                w_cmd.acc = (r_k < 3'd3);
                case (r_pass)
                    2'd0:    begin ma = r_rc[w_i][w_kk]; mb = r_w[w_j][w_kk]; end
                    2'd1:    begin ma = r_a[w_i][w_kk];  mb = r_wref[w_kk][w_j]; end
                    default: begin ma = r_b[w_i][w_kk];  mb = r_rc[w_j][w_kk]; end
                endcase
                w_cmd.a = 33'(ma);
                w_cmd.b = 18'(mb);
            end
            S_TRANS: begin
                // elem = row, pass 0: A*(tref-t), pass 1: R*tc
                w_cmd.acc = (r_k < 3'd3);
                if (r_pass == 2'd0) begin
                    w_cmd.a = 33'(r_tref[w_kk]) - 33'(r_pos[w_kk]);
                    w_cmd.b = 18'(r_a[r_elem[1:0]][w_kk]);
                end else begin
                    w_cmd.a = 33'(r_tc[w_kk]);
                    w_cmd.b = 18'(r_r[r_elem[1:0]][w_kk]);
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_out;

    logic signed [63:0] w_r14;
    assign w_r14 = rpet_pkg::rnd_shift(w_acc, 4'd14);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_count <= '0;
            r_start <= rpet_pkg::START_RESET;
            for (int i = 0; i < 3; i++) begin
                r_tc[i]   <= '0;
                r_tref[i] <= '0;
                for (int j = 0; j < 3; j++) begin
                    r_rc[i][j]   <= '0;
                    r_wref[i][j] <= (i == j) ? rpet_pkg::ONE_Q14 : 16'sd0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rpet_pkg::CFG_START: r_start <= i_cfg_data;
                    rpet_pkg::CFG_ROT0, rpet_pkg::CFG_ROT1, rpet_pkg::CFG_ROT2: begin
                        for (int j = 0; j < 3; j++)
                            r_rc[2'(i_cfg_index - rpet_pkg::CFG_ROT0)][j]
                                <= i_cfg_data[16*j +: 16];
                    end
                    rpet_pkg::CFG_TX: r_tc[0] <= i_cfg_data[31:0];
                    rpet_pkg::CFG_TY: r_tc[1] <= i_cfg_data[31:0];
                    rpet_pkg::CFG_TZ: r_tc[2] <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_stamp <= s_axis_tdata[63:0];
                        r_q[0]  <= s_axis_tdata[78:64];
                        r_q[1]  <= s_axis_tdata[93:79];
                        r_q[2]  <= s_axis_tdata[108:94];
                        r_q[3]  <= s_axis_tdata[123:109];
                        r_pos[0] <= s_axis_tdata[155:124];
                        r_pos[1] <= s_axis_tdata[187:156];
                        r_pos[2] <= s_axis_tdata[219:188];
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_stamp < r_start) begin
                        r_state <= S_IDLE;
                    end else begin
                        if (r_count != 32'hffff_ffff)
                            r_count <= r_count + 32'd1;
                        r_elem  <= '0;
                        r_k     <= '0;
                        r_state <= S_QUAT;
                    end
                end
                S_QUAT: begin
                    if (r_k == 3'd2) begin
                        logic signed [63:0] v;
                        v = rpet_pkg::rnd_shift(w_acc, 4'd13);
                        if (r_elem == 4'd0 || r_elem == 4'd4 || r_elem == 4'd8)
                            v = 64'sd16384 - v;
                        r_w[w_i][w_j] <= rpet_pkg::sat16(v);
                        r_k <= '0;
                        if (r_elem == 4'd8) begin
                            r_elem <= '0;
                            if (r_count == 32'd1) begin
                                r_state <= S_OUT;
                            end else begin
                                r_pass  <= 2'd0;
                                r_state <= S_MAT;
                            end
                        end else begin
                            r_elem <= r_elem + 4'd1;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_MAT: begin
                    if (r_k == 3'd3) begin
                        case (r_pass)
                            2'd0:    r_a[w_i][w_j] <= rpet_pkg::sat16(w_r14);
                            2'd1:    r_b[w_i][w_j] <= rpet_pkg::sat16(w_r14);
                            default: r_r[w_i][w_j] <= rpet_pkg::sat16(w_r14);
                        endcase
                        r_k <= '0;
                        if (r_elem == 4'd8) begin
                            r_elem <= '0;
                            if (r_pass == 2'd2) begin
                                r_pass  <= 2'd0;
                                r_state <= S_TRANS;
                            end else begin
                                r_pass <= r_pass + 2'd1;
                            end
                        end else begin
                            r_elem <= r_elem + 4'd1;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_TRANS: begin
                    if (r_k == 3'd3) begin
                        r_k <= '0;
                        if (r_pass == 2'd0) begin
                            r_p1   <= 36'(w_r14);
                            r_pass <= 2'd1;
                        end else begin
                            r_t[r_elem[1:0]] <= rpet_pkg::sat32(64'(r_p1)
                                + 64'(r_tc[r_elem[1:0]]) - w_r14);
                            r_pass <= 2'd0;
                            if (r_elem == 4'd2)
                                r_state <= S_OUT;
                            else
                                r_elem <= r_elem + 4'd1;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_OUT: begin
                    // reference pose: store it; otherwise wait for a free result register
                    if (r_count == 32'd1) begin
                        r_wref  <= r_w;
                        r_tref  <= r_pos;
                        r_state <= S_IDLE;
                    end else if (!r_oval) begin
                        r_out <= {r_t[2], r_t[1], r_t[0],
                                  r_r[2][2], r_r[2][1], r_r[2][0],
                                  r_r[1][2], r_r[1][1], r_r[1][0],
                                  r_r[0][2], r_r[0][1], r_r[0][0],
                                  r_stamp, r_count};
                        r_oval  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== dv/rpet_checker.sv =====
// Checker for the relative pose core: watches the channels, predicts each result, compares.
module rpet_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [223:0]  s_axis_tdata,
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [335:0]  m_axis_tdata,
    output int            o_errors,
    output int            o_pending,
    output int            o_results,
    output int            o_dropped
);

    typedef longint t_mat3 [3][3];

    typedef struct {
        logic [31:0] frame_index;
        logic [63:0] stamp;
        logic [47:0] row [3];
        logic [31:0] trans [3];
    } t_pose_result;

    // shadow of the register file and the reference pose
    logic [63:0] start_ns;
    t_mat3       extr_rot;
    longint      extr_t [3];
    logic [31:0] pose_count;
    t_mat3       ref_rot;
    longint      ref_t [3];

    t_pose_result expected_poses [$];

    function automatic longint rshift_rnd(longint x, int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint clamp16(longint x);
        return clamp(x, -32768, 32767);
    endfunction

    // c = a * b, or a * b^T when transposed is set
    function automatic t_mat3 mat_mult(t_mat3 a, t_mat3 b, bit transposed);
        t_mat3  c;
        longint s;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                s = 0;
                for (int k = 0; k < 3; k++)
                    s += a[i][k] * (transposed ? b[j][k] : b[k][j]);
                c[i][j] = clamp16(rshift_rnd(s, 14));
            end
        return c;
    endfunction

    function automatic t_mat3 quat_rotation(longint x, longint y, longint z, longint w);
        t_mat3 r;
        r[0][0] = clamp16(16384 - rshift_rnd(y*y + z*z, 13));
        r[0][1] = clamp16(rshift_rnd(x*y - z*w, 13));
        r[0][2] = clamp16(rshift_rnd(x*z + y*w, 13));
        r[1][0] = clamp16(rshift_rnd(x*y + z*w, 13));
        r[1][1] = clamp16(16384 - rshift_rnd(x*x + z*z, 13));
        r[1][2] = clamp16(rshift_rnd(y*z - x*w, 13));
        r[2][0] = clamp16(rshift_rnd(x*z - y*w, 13));
        r[2][1] = clamp16(rshift_rnd(y*z + x*w, 13));
        r[2][2] = clamp16(16384 - rshift_rnd(x*x + y*y, 13));
        return r;
    endfunction

    function automatic logic [47:0] pack_row(t_mat3 m, int i);
        logic [47:0] r;
        for (int j = 0; j < 3; j++)
            r[16*j +: 16] = m[i][j][15:0];
        return r;
    endfunction

    // one accepted pose: update state, queue a result when one is due
    task automatic predict_pose(logic [223:0] d);
        t_mat3        world, a_m, b_m, rel;
        longint       pos [3];
        longint       s1, s2, t;
        t_pose_result res;
        if (d[63:0] < start_ns) begin
            o_dropped++;
            return;
        end
        if (pose_count != 32'hffff_ffff)
            pose_count++;
        world = quat_rotation(longint'($signed(d[78:64])), longint'($signed(d[93:79])),
                              longint'($signed(d[108:94])), longint'($signed(d[123:109])));
        for (int i = 0; i < 3; i++)
            pos[i] = longint'($signed(d[124 + 32*i +: 32]));
        if (pose_count == 1) begin
            ref_rot = world;
            ref_t   = pos;
            return;
        end
        a_m = mat_mult(extr_rot, world, 1'b1);
        b_m = mat_mult(a_m, ref_rot, 1'b0);
        rel = mat_mult(b_m, extr_rot, 1'b1);
        res.frame_index = pose_count;
        res.stamp       = d[63:0];
        for (int i = 0; i < 3; i++) begin
            res.row[i] = pack_row(rel, i);
            s1 = 0;
            s2 = 0;
            for (int k = 0; k < 3; k++) begin
                s1 += a_m[i][k] * (ref_t[k] - pos[k]);
                s2 += rel[i][k] * extr_t[k];
            end
            t = rshift_rnd(s1, 14) + extr_t[i] - rshift_rnd(s2, 14);
            res.trans[i] = 32'(clamp(t, -64'sd2147483648, 64'sd2147483647));
        end
        expected_poses.push_back(res);
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            o_errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_pose_result exp_r;
        if (!i_rst_n) begin
            start_ns   <= rpet_pkg::START_RESET;
            pose_count <= '0;
            for (int i = 0; i < 3; i++) begin
                extr_t[i] <= 0;
                ref_t[i]  <= 0;
                for (int j = 0; j < 3; j++) begin
                    extr_rot[i][j] <= 0;
                    ref_rot[i][j]  <= (i == j) ? 16384 : 0;
                end
            end
            expected_poses.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rpet_pkg::CFG_START: start_ns = i_cfg_data;
                    rpet_pkg::CFG_ROT0, rpet_pkg::CFG_ROT1, rpet_pkg::CFG_ROT2:
                        for (int j = 0; j < 3; j++)
                            extr_rot[i_cfg_index - rpet_pkg::CFG_ROT0][j] =
                                longint'($signed(i_cfg_data[16*j +: 16]));
                    rpet_pkg::CFG_TX, rpet_pkg::CFG_TY, rpet_pkg::CFG_TZ:
                        extr_t[i_cfg_index - rpet_pkg::CFG_TX] =
                            longint'($signed(i_cfg_data[31:0]));
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_pose(s_axis_tdata);
            // result compare against the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                o_results++;
                if (expected_poses.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                end else begin
                    exp_r = expected_poses.pop_front();
                    check_field("frame_index", exp_r.frame_index, m_axis_tdata[31:0]);
                    check_field("out_stamp_ns", exp_r.stamp, m_axis_tdata[95:32]);
                    for (int i = 0; i < 3; i++) begin
                        check_field($sformatf("rel_rot_row%0d", i), exp_r.row[i],
                                    m_axis_tdata[96 + 48*i +: 48]);
                        check_field($sformatf("rel_trans_%0d", i), exp_r.trans[i],
                                    m_axis_tdata[240 + 32*i +: 32]);
                    end
                end
            end
        end
        o_pending = expected_poses.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
        o_dropped = 0;
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the relative pose core: stimulus, configuration phases and verdict.
module tb;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_index = rpet_pkg::CFG_START;
    logic [63:0]   i_cfg_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [223:0]  s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [335:0]  m_axis_tdata;

    int errors, pending, results, dropped;
    int poses_sent = 0;
    int stall_left = 0;
    bit held_off = 1'b0;

    always #2 i_clk = ~i_clk;

    relative_pose_extrinsic_transform_core u_dut (.*);

    rpet_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_dropped(dropped)
    );

    // receiver: random stalls, one long hold-off once the run is under way
    always @(posedge i_clk) begin
        if (!held_off && poses_sent >= 300) begin
            held_off      <= 1'b1;
            stall_left    <= 400;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 20) begin
            stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // stop offering, then wait until the core is idle and every result is back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || !s_axis_tready)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_pose(logic [63:0] stamp, logic [14:0] qx, logic [14:0] qy,
                             logic [14:0] qz, logic [14:0] qw,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, pz, py, px, qw, qz, qy, qx, stamp};
        do @(posedge i_clk); while (!s_axis_tready);
        poses_sent++;
        gap = ($urandom_range(0, 1) == 0) ? 0 :
              (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // random pose; small quaternion components (within +-8000) most of the time, raw values otherwise
    task automatic random_pose(logic [63:0] stamp);
        logic [14:0] q [4];
        int          big;
        big = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++)
            q[i] = (big == 0) ? 15'($urandom) : 15'($signed($urandom_range(0, 16000)) - 8000);
        send_pose(stamp, q[0], q[1], q[2], q[3], $urandom, $urandom,
                  ($urandom_range(0, 3) == 0) ? $urandom
                                              : 32'($signed($urandom_range(0, 2000000))
                                                    - 1000000));
    endtask

    task automatic random_extrinsic();
        for (int r = 0; r < 3; r++)
            cfg_write(rpet_pkg::CFG_ROT0 + 3'(r), {$urandom, $urandom});
        cfg_write(rpet_pkg::CFG_TX, {32'b0, $urandom});
        cfg_write(rpet_pkg::CFG_TY, {32'b0, $urandom});
        cfg_write(rpet_pkg::CFG_TZ, {32'b0, $urandom});
    endtask

    initial begin
        logic [63:0] st;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, early stamps, reference pose, field extremes
        send_pose(64'd0, 15'h4000, 15'h3fff, 15'h0, 15'h0, 32'h8000_0000, 32'h7fff_ffff, '0);
        send_pose(rpet_pkg::START_RESET - 1, '0, '0, '0, '0, '0, '0, '0);
        send_pose(rpet_pkg::START_RESET, '0, '0, '0, 15'h3fff, 32'h0001_0000, '0, '0);
        send_pose(rpet_pkg::START_RESET + 1, 15'h4000, 15'h4000, 15'h4000, 15'h4000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_pose('1, 15'h3fff, 15'h3fff, 15'h3fff, 15'h3fff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        wait_idle();

        // identity extrinsic, start at zero
        cfg_write(rpet_pkg::CFG_START, '0);
        cfg_write(rpet_pkg::CFG_ROT0, {16'd0, 16'd0, 16'd16384});
        cfg_write(rpet_pkg::CFG_ROT1, {16'd0, 16'd16384, 16'd0});
        cfg_write(rpet_pkg::CFG_ROT2, {16'd16384, 16'd0, 16'd0});
        cfg_write(rpet_pkg::CFG_TX, 64'h0000_0000_0001_8000);
        cfg_write(rpet_pkg::CFG_TY, 64'h0000_0000_fff0_0000);
        cfg_write(rpet_pkg::CFG_TZ, 64'h0000_0000_0000_4000);
        send_pose('0, '0, '0, '0, 15'h3fff, '0, '0, '0);
        send_pose(64'd5, 15'h4000, '0, '0, '0, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000);
        send_pose(64'd6, '0, 15'h4000, '0, '0, '0, '0, '0);
        send_pose(64'd7, '0, '0, 15'h3fff, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        for (int n = 0; n < 150; n++)
            random_pose({$urandom, $urandom});
        wait_idle();

        // random extrinsic, mid start time with a share of early stamps
        st = {1'b0, 31'($urandom), $urandom};
        cfg_write(rpet_pkg::CFG_START, st);
        random_extrinsic();
        for (int n = 0; n < 200; n++)
            random_pose(($urandom_range(0, 4) == 0) ? st - $urandom_range(1, 1000)
                                                    : st + {$urandom, $urandom} % (~st + 1));
        wait_idle();

        // extreme extrinsic and translation, start time at its top
        cfg_write(rpet_pkg::CFG_START, '1);
        cfg_write(rpet_pkg::CFG_ROT0, 64'h0000_8000_8000_8000);
        cfg_write(rpet_pkg::CFG_ROT1, 64'h0000_7fff_7fff_7fff);
        cfg_write(rpet_pkg::CFG_ROT2, 64'h0000_8000_7fff_8000);
        cfg_write(rpet_pkg::CFG_TX, 64'h0000_0000_7fff_ffff);
        cfg_write(rpet_pkg::CFG_TY, 64'h0000_0000_8000_0000);
        cfg_write(rpet_pkg::CFG_TZ, 64'h0000_0000_7fff_ffff);
        for (int n = 0; n < 40; n++)
            random_pose(($urandom_range(0, 1) == 0) ? 64'hffff_ffff_ffff_ffff
                                                    : {$urandom, $urandom});
        wait_idle();

        // random extrinsic again, every stamp accepted
        cfg_write(rpet_pkg::CFG_START, '0);
        random_extrinsic();
        for (int n = 0; n < 160; n++)
            random_pose({$urandom, $urandom});
        wait_idle();

        $display("poses sent %0d, dropped as early %0d, results checked %0d",
                 poses_sent, dropped, results);
        $display("covered four extrinsic settings, saturating quaternions and receiver hold-off");
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d results outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rpet_pkg.sv
src/rpet_mac.sv
src/relative_pose_extrinsic_transform_core.sv
dv/rpet_checker.sv
dv/tb.sv
